FILE: rtl/rect_polar_converter_macros.svh
// assertion macros shared by the checker of rect_polar_converter
// no dependencies; include by bare file name
`ifndef RECT_POLAR_CONVERTER_MACROS_SVH
`define RECT_POLAR_CONVERTER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rpc_pkg.sv
// shared constants and types of the rectangular/polar cordic converter
// no dependencies
package rpc_pkg;

	localparam int ITERATIONS_DEF = 16;
	localparam int DATA_WIDTH_DEF = 16;
	// extra fraction bits carried through the rotation
	localparam int GUARD = 16;
	localparam int ATAN_COUNT = 24;
	// angle accumulator width, 32 bits per turn plus headroom
	localparam int ZW = 34;
	// 1/K scaled by 2^32
	localparam logic [31:0] INV_GAIN = 32'd2608131496;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// atan(2^-i), 2^32 per full turn
	localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef enum logic {
		CMD_TO_POLAR = 1'b0,
		CMD_TO_RECT  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic origin;
	} rpc_ctl_t;

endpackage

FILE: rtl/rpc_cell.sv
// one cordic micro-rotation stage, a cell of the rotation chain
// depends on rpc_pkg
module rpc_cell #(
	parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
	parameter int IDX = 0,
	localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3
) (
	input  logic clk,
	input  logic arst_n,
	input  rpc_pkg::rpc_ctl_t ctl,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	input  logic signed [rpc_pkg::ZW-1:0] z,
	input  logic signed [DATA_WIDTH-1:0] echo_a,
	input  logic signed [DATA_WIDTH-1:0] echo_b,
	output rpc_pkg::rpc_ctl_t ctl_q,
	output logic signed [XW-1:0] x_q,
	output logic signed [XW-1:0] y_q,
	output logic signed [rpc_pkg::ZW-1:0] z_q,
	output logic signed [DATA_WIDTH-1:0] echo_a_q,
	output logic signed [DATA_WIDTH-1:0] echo_b_q
);

	logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
	logic signed [rpc_pkg::ZW-1:0] da, z_nxt;

	assign dx = x >>> IDX;
	assign dy = y >>> IDX;
	assign da = $signed({{(rpc_pkg::ZW-32){1'b0}}, rpc_pkg::ATAN_TURN[IDX]});

	// vectoring drives y to zero, rotation drives z to zero
	always_comb begin
		x_nxt = x;
		y_nxt = y;
		z_nxt = z;
		unique case (ctl.cmd)
			rpc_pkg::CMD_TO_POLAR: begin
				if (!y[XW-1]) begin
					x_nxt = x + dy;
					y_nxt = y - dx;
					z_nxt = z + da;
				end else begin
					x_nxt = x - dy;
					y_nxt = y + dx;
					z_nxt = z - da;
				end
			end
			rpc_pkg::CMD_TO_RECT: begin
				if (!z[rpc_pkg::ZW-1]) begin
					x_nxt = x - dy;
					y_nxt = y + dx;
					z_nxt = z - da;
				end else begin
					x_nxt = x + dy;
					y_nxt = y - dx;
					z_nxt = z + da;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		x_q      <= x_nxt;
		y_q      <= y_nxt;
		z_q      <= z_nxt;
		echo_a_q <= echo_a;
		echo_b_q <= echo_b;
	end

endmodule

FILE: rtl/rpc_pre.sv
// input conditioning: half-plane fold, gain prescale of the radius
// depends on rpc_pkg
module rpc_pre #(
	parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
	localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic command,
	input  logic signed [DATA_WIDTH-1:0] real_in,
	input  logic signed [DATA_WIDTH-1:0] imag_in,
	input  logic signed [DATA_WIDTH-1:0] magnitude_in,
	input  logic signed [DATA_WIDTH-1:0] angle_in,
	output rpc_pkg::rpc_ctl_t ctl_s2,
	output logic signed [XW-1:0] x_s2,
	output logic signed [XW-1:0] y_s2,
	output logic signed [rpc_pkg::ZW-1:0] z_s2,
	output logic signed [DATA_WIDTH-1:0] echo_a_s2,
	output logic signed [DATA_WIDTH-1:0] echo_b_s2
);

	localparam int SH = 32 - DATA_WIDTH;
	localparam int PW = DATA_WIDTH + 32;
	localparam logic [PW-1:0] PROD_RND = PW'(1) << (31 - rpc_pkg::GUARD);

	// stage 1
	rpc_pkg::rpc_ctl_t ctl_d, ctl_s1;
	logic signed [XW-1:0] re_x, im_x, x_d, y_d, x_s1, y_s1;
	logic signed [rpc_pkg::ZW-1:0] z_d, z_s1;
	logic [31:0] z32, zf;
	logic fold;
	logic signed [DATA_WIDTH:0] r_ext, r_fold, r_abs;
	logic [DATA_WIDTH-1:0] ar_s1;
	logic rneg_s1;
	logic signed [DATA_WIDTH-1:0] echo_a_s1, echo_b_s1;

	// stage 2
	logic [PW-1:0] prod, prod_r;
	logic signed [XW-1:0] s_x;

	always_comb begin
		ctl_d.valid  = accept;
		ctl_d.cmd    = rpc_pkg::cmd_t'(command);
		ctl_d.origin = (ctl_d.cmd == rpc_pkg::CMD_TO_POLAR) && (real_in == '0) && (imag_in == '0);

		// left half plane is turned by pi before vectoring
		re_x = XW'(real_in) <<< rpc_pkg::GUARD;
		im_x = XW'(imag_in) <<< rpc_pkg::GUARD;

		// second and third quadrant angles fold by pi with the radius negated
		z32    = 32'(angle_in) << SH;
		fold   = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
		zf     = fold ? (z32 - rpc_pkg::HALF_TURN) : z32;
		r_ext  = (DATA_WIDTH+1)'(magnitude_in);
		r_fold = fold ? -r_ext : r_ext;
		r_abs  = r_fold[DATA_WIDTH] ? -r_fold : r_fold;

		if (ctl_d.cmd == rpc_pkg::CMD_TO_POLAR) begin
			x_d = real_in[DATA_WIDTH-1] ? -re_x : re_x;
			y_d = real_in[DATA_WIDTH-1] ? -im_x : im_x;
			z_d = real_in[DATA_WIDTH-1] ?
				$signed({{(rpc_pkg::ZW-32){1'b0}}, rpc_pkg::HALF_TURN}) : '0;
		end else begin
			x_d = '0;
			y_d = '0;
			z_d = rpc_pkg::ZW'($signed(zf));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1      <= x_d;
		y_s1      <= y_d;
		z_s1      <= z_d;
		ar_s1     <= r_abs[DATA_WIDTH-1:0];
		rneg_s1   <= r_fold[DATA_WIDTH];
		echo_a_s1 <= (ctl_d.cmd == rpc_pkg::CMD_TO_RECT) ? magnitude_in : real_in;
		echo_b_s1 <= (ctl_d.cmd == rpc_pkg::CMD_TO_RECT) ? angle_in : imag_in;
	end

	// radius times 1/K, rounded to GUARD fraction bits
	assign prod   = PW'(ar_s1) * PW'(rpc_pkg::INV_GAIN);
	assign prod_r = prod + PROD_RND;
	assign s_x    = $signed(XW'(prod_r[PW-1:32-rpc_pkg::GUARD]));

	always_ff @(posedge clk) begin
		if (ctl_s1.cmd == rpc_pkg::CMD_TO_RECT) begin
			x_s2 <= rneg_s1 ? -s_x : s_x;
			y_s2 <= '0;
		end else begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
		end
		z_s2      <= z_s1;
		echo_a_s2 <= echo_a_s1;
		echo_b_s2 <= echo_b_s1;
	end

endmodule

FILE: rtl/rpc_post.sv
// output stage: gain removal, rounding, saturation and result select
// depends on rpc_pkg
module rpc_post #(
	parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF,
	localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3
) (
	input  logic clk,
	input  logic arst_n,
	input  rpc_pkg::rpc_ctl_t ctl,
	input  logic signed [XW-1:0] x,
	input  logic signed [XW-1:0] y,
	input  logic signed [rpc_pkg::ZW-1:0] z,
	input  logic signed [DATA_WIDTH-1:0] echo_a,
	input  logic signed [DATA_WIDTH-1:0] echo_b,
	output logic done,
	output logic signed [DATA_WIDTH-1:0] real_out,
	output logic signed [DATA_WIDTH-1:0] imag_out,
	output logic signed [DATA_WIDTH:0] magnitude_out,
	output logic signed [DATA_WIDTH-1:0] angle_out
);

	localparam int SH = 32 - DATA_WIDTH;
	localparam int RW = DATA_WIDTH + 3;
	localparam logic [32:0] ANG_RND = (33'(1) << SH) >> 1;
	localparam logic signed [XW-1:0] HALF = XW'(1) <<< (rpc_pkg::GUARD - 1);
	localparam logic [63:0] MAG_RND = 64'(1) << (rpc_pkg::GUARD - 1);
	localparam logic signed [RW-1:0] SAT_HI = $signed({4'b0000, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [RW-1:0] SAT_LO = $signed({4'b1111, {(DATA_WIDTH-1){1'b0}}});

	rpc_pkg::rpc_ctl_t ctl_s1, ctl_s2;
	logic [63:0] a64, phi_s1, plo_s1, t_sum, t_rnd;
	logic signed [XW-1:0] xh, yh;
	logic signed [RW-1:0] xr_s1, yr_s1;
	logic [32:0] z_rnd;
	logic [DATA_WIDTH-1:0] ang_s1;
	logic signed [DATA_WIDTH-1:0] echo_a_s1, echo_b_s1;
	logic signed [DATA_WIDTH-1:0] real_s2, imag_s2, angle_s2;
	logic signed [DATA_WIDTH:0] mag_s2;

	function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[DATA_WIDTH-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[DATA_WIDTH-1:0];
		end else begin
			r = v[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

	// only a positive x contributes to the magnitude
	assign a64   = (!x[XW-1] && (x != '0)) ? {{(64-XW){1'b0}}, x} : '0;
	assign xh    = x + HALF;
	assign yh    = y + HALF;
	assign z_rnd = {1'b0, z[31:0]} + ANG_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
		end
	end

	// split product keeps each multiplier at 32 by 32
	always_ff @(posedge clk) begin
		phi_s1    <= 64'(a64[63:32]) * 64'(rpc_pkg::INV_GAIN);
		plo_s1    <= 64'(a64[31:0]) * 64'(rpc_pkg::INV_GAIN);
		xr_s1     <= xh[XW-1:rpc_pkg::GUARD];
		yr_s1     <= yh[XW-1:rpc_pkg::GUARD];
		ang_s1    <= z_rnd[31 -: DATA_WIDTH];
		echo_a_s1 <= echo_a;
		echo_b_s1 <= echo_b;
	end

	assign t_sum = phi_s1 + (plo_s1 >> 32);
	assign t_rnd = t_sum + MAG_RND;

	always_ff @(posedge clk) begin
		unique case (ctl_s1.cmd)
			rpc_pkg::CMD_TO_POLAR: begin
				real_s2  <= echo_a_s1;
				imag_s2  <= echo_b_s1;
				mag_s2   <= ctl_s1.origin ? '0 : $signed(t_rnd[rpc_pkg::GUARD +: DATA_WIDTH+1]);
				angle_s2 <= ctl_s1.origin ? '0 : $signed(ang_s1);
			end
			rpc_pkg::CMD_TO_RECT: begin
				real_s2  <= sat(xr_s1);
				imag_s2  <= sat(yr_s1);
				mag_s2   <= (DATA_WIDTH+1)'(echo_a_s1);
				angle_s2 <= echo_b_s1;
			end
		endcase
	end

	assign done          = ctl_s2.valid;
	assign real_out      = real_s2;
	assign imag_out      = imag_s2;
	assign magnitude_out = mag_s2;
	assign angle_out     = angle_s2;

endmodule

FILE: rtl/rect_polar_converter.sv
// top level of the rectangular/polar cordic converter
// depends on rpc_pkg, rpc_pre, rpc_cell, rpc_post
//
// converts one complex number per item, in either direction, chosen by
// command: 0 takes real_in/imag_in to magnitude and angle, 1 takes
// magnitude_in/angle_in to real and imaginary parts. all four result
// fields always describe the same number; the operands given are echoed.
// angles are binary, 2^(DATA_WIDTH-1) is pi. the block is a pipeline:
// two prescale stages, a chain of ITERATIONS rotation cells, and two
// output stages; a new item is taken on every clock while busy is low.
// busy is high during reset and until the ready register is set after
// it, and low from then on. the receiver cannot stall: each result is on
// the output ports for exactly one cycle, flagged by done, and the block
// never holds one back, so the consumer must take every done cycle as it
// comes.
module rect_polar_converter #(
	parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF,
	parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic signed [DATA_WIDTH-1:0] real_in,
	input  logic signed [DATA_WIDTH-1:0] imag_in,
	input  logic signed [DATA_WIDTH-1:0] magnitude_in,
	input  logic signed [DATA_WIDTH-1:0] angle_in,
	output logic done,
	output logic signed [DATA_WIDTH-1:0] real_out,
	output logic signed [DATA_WIDTH-1:0] imag_out,
	output logic signed [DATA_WIDTH:0] magnitude_out,
	output logic signed [DATA_WIDTH-1:0] angle_out
);

	// datapath width: operand, guard fraction bits, cordic growth and sign
	localparam int XW = DATA_WIDTH + rpc_pkg::GUARD + 3;

	logic ready_q;
	logic accept;

	// one slot per cell boundary; slot 0 is fed by the prescale stages
	rpc_pkg::rpc_ctl_t ctl_c [ITERATIONS+1];
	logic signed [XW-1:0] x_c [ITERATIONS+1];
	logic signed [XW-1:0] y_c [ITERATIONS+1];
	logic signed [rpc_pkg::ZW-1:0] z_c [ITERATIONS+1];
	logic signed [DATA_WIDTH-1:0] ea_c [ITERATIONS+1];
	logic signed [DATA_WIDTH-1:0] eb_c [ITERATIONS+1];

	// ready is registered: it rises at the first clock after reset is released and stays up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && !busy;

	// fold into the right half plane, prescale the radius by 1/K
	rpc_pre #(.DATA_WIDTH(DATA_WIDTH)) u_pre (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.real_in      (real_in),
		.imag_in      (imag_in),
		.magnitude_in (magnitude_in),
		.angle_in     (angle_in),
		.ctl_s2       (ctl_c[0]),
		.x_s2         (x_c[0]),
		.y_s2         (y_c[0]),
		.z_s2         (z_c[0]),
		.echo_a_s2    (ea_c[0]),
		.echo_b_s2    (eb_c[0])
	);

	// rotation chain, one micro-rotation per cell and per cycle
	for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
		rpc_cell #(.DATA_WIDTH(DATA_WIDTH), .IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_c[k]),
			.x        (x_c[k]),
			.y        (y_c[k]),
			.z        (z_c[k]),
			.echo_a   (ea_c[k]),
			.echo_b   (eb_c[k]),
			.ctl_q    (ctl_c[k+1]),
			.x_q      (x_c[k+1]),
			.y_q      (y_c[k+1]),
			.z_q      (z_c[k+1]),
			.echo_a_q (ea_c[k+1]),
			.echo_b_q (eb_c[k+1])
		);
	end

	// remove the gain, round, saturate and pick the result fields
	rpc_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl_c[ITERATIONS]),
		.x             (x_c[ITERATIONS]),
		.y             (y_c[ITERATIONS]),
		.z             (z_c[ITERATIONS]),
		.echo_a        (ea_c[ITERATIONS]),
		.echo_b        (eb_c[ITERATIONS]),
		.done          (done),
		.real_out      (real_out),
		.imag_out      (imag_out),
		.magnitude_out (magnitude_out),
		.angle_out     (angle_out)
	);

endmodule

FILE: rtl/rpc_checker.sv
// port-level checks of rect_polar_converter, bound to the top level
// depends on rpc_pkg and rect_polar_converter_macros.svh
`include "rect_polar_converter_macros.svh"

module rpc_port_checker #(
	parameter int ITERATIONS = rpc_pkg::ITERATIONS_DEF,
	parameter int DATA_WIDTH = rpc_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic signed [DATA_WIDTH-1:0] real_in,
	input logic signed [DATA_WIDTH-1:0] imag_in,
	input logic signed [DATA_WIDTH-1:0] magnitude_in,
	input logic signed [DATA_WIDTH-1:0] angle_in,
	input logic done,
	input logic signed [DATA_WIDTH-1:0] real_out,
	input logic signed [DATA_WIDTH-1:0] imag_out,
	input logic signed [DATA_WIDTH:0] magnitude_out,
	input logic signed [DATA_WIDTH-1:0] angle_out
);

	localparam int LAT = ITERATIONS + 4;

	// accepted items in flight, cleared with the block
	logic [LAT-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= {acc_q[LAT-2:0], start && !busy};
		end
	end

	`RPC_ASSERT_IMPLY(a_done_latency, clk, arst_n, 1'b1, done == acc_q[LAT-1], "done not at fixed latency")

	`RPC_ASSERT_IMPLY(a_polar_echo, clk, arst_n, done && !$past(command, LAT), (real_out == $past(real_in, LAT)) && (imag_out == $past(imag_in, LAT)) && !magnitude_out[DATA_WIDTH], "polar result lost operands or negative magnitude")

	`RPC_ASSERT_IMPLY(a_origin, clk, arst_n, done && !$past(command, LAT) && ($past(real_in, LAT) == '0) && ($past(imag_in, LAT) == '0), (magnitude_out == '0) && (angle_out == '0), "origin not mapped to zero")

	`RPC_ASSERT_IMPLY(a_rect_echo, clk, arst_n, done && $past(command, LAT), (angle_out == $past(angle_in, LAT)) && (magnitude_out == (DATA_WIDTH+1)'($past(magnitude_in, LAT))), "rect result lost operands")

	`RPC_ASSERT_NEXT(a_busy_stays_low, clk, arst_n, !busy, !busy, "busy rose outside reset")

endmodule

bind rect_polar_converter rpc_port_checker #(
	.ITERATIONS (ITERATIONS),
	.DATA_WIDTH (DATA_WIDTH)
) u_rpc_checker (.*);
